>>> rtl/isn_pkg.sv
`timescale 1ns / 1ps

package isn_pkg;

    localparam int POS_W = 17;
    localparam int TGT_W = 18;
    localparam logic [POS_W-1:0] SCAN_LIMIT = 17'h10000;

    localparam logic [7:0] MAGIC_PNG0 = 8'h89;
    localparam logic [7:0] MAGIC_JPG0 = 8'hFF;
    localparam logic [7:0] MAGIC_JPG1 = 8'hD8;
    localparam logic [7:0] JPG_MARK   = 8'hFF;
    localparam logic [7:0] SOF_FIRST  = 8'hC0;
    localparam logic [7:0] SOF_LAST   = 8'hCF;
    localparam logic [7:0] DHT_CODE   = 8'hC4;
    localparam logic [7:0] JPG_CODE   = 8'hC8;
    localparam logic [7:0] DAC_CODE   = 8'hCC;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_PNG  = 3'd1,
        FMT_GIF  = 3'd2,
        FMT_BMP  = 3'd3,
        FMT_JPEG = 3'd4
    } t_fmt;

    typedef enum logic [2:0] {
        PH_SEEK  = 3'd0,
        PH_CODE  = 3'd1,
        PH_FRAME = 3'd2,
        PH_LENHI = 3'd3,
        PH_LENLO = 3'd4
    } t_jphase;

    typedef struct packed {
        logic             en;
        logic             step;
        logic             clear;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } t_jpeg_ctl;

    typedef struct packed {
        logic cap_h_hi;
        logic cap_h_lo;
        logic cap_w_hi;
        logic cap_w_lo;
        logic done;
    } t_jpeg_evt;

    function automatic logic is_frame_code(input logic [7:0] m);
        return (m >= SOF_FIRST) && (m <= SOF_LAST) && (m != DHT_CODE)
            && (m != JPG_CODE) && (m != DAC_CODE);
    endfunction

endpackage

>>> rtl/isn_if.sv
`timescale 1ns / 1ps

interface isn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface isn_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [2:0]         image_format;
    logic signed [31:0] pixel_width;
    logic signed [31:0] pixel_height;

    modport source (output valid, output found, output image_format,
                    output pixel_width, output pixel_height, input ready);
    modport sink   (input valid, input found, input image_format,
                    input pixel_width, input pixel_height, output ready);
endinterface

>>> rtl/isn_jpeg.sv
`timescale 1ns / 1ps

module isn_jpeg
    import isn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_jpeg_ctl i_ctl,
    output t_jpeg_evt o_evt
);

    t_jphase          r_phase, n_phase;
    logic [TGT_W-1:0] r_target, n_target;
    logic [POS_W-1:0] r_start, n_start;
    logic [15:0]      r_len, n_len;
    logic [POS_W-1:0] rel;
    logic [15:0]      len16;
    t_jpeg_evt        evt;

    always_comb begin
        n_phase  = r_phase;
        n_target = r_target;
        n_start  = r_start;
        n_len    = r_len;
        evt      = '0;
        rel      = i_ctl.pos - r_start;
        len16    = {r_len[7:0], i_ctl.data};
        case (r_phase)
            PH_SEEK: begin
                if ({1'b0, i_ctl.pos} == r_target) begin
                    if (i_ctl.data != JPG_MARK) begin
                        n_target = r_target + 18'd1;
                    end else begin
                        n_start = i_ctl.pos;
                        n_phase = PH_CODE;
                    end
                end
            end
            PH_CODE: begin
                n_phase = is_frame_code(i_ctl.data) ? PH_FRAME : PH_LENHI;
            end
            PH_FRAME: begin
                evt.cap_h_hi = (rel == 17'd5);
                evt.cap_h_lo = (rel == 17'd6);
                evt.cap_w_hi = (rel == 17'd7);
                evt.cap_w_lo = (rel == 17'd8);
                evt.done     = (rel == 17'd9);
            end
            PH_LENHI: begin
                n_len   = {8'd0, i_ctl.data};
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                n_len = len16;
                if (len16 < 16'd2) begin
                    n_target = {1'b0, r_start} + 18'd4;
                end else begin
                    n_target = {1'b0, r_start} + 18'd2 + {2'b00, len16};
                end
                n_phase = PH_SEEK;
            end
            default: begin
                n_phase = PH_SEEK;
            end
        endcase
    end

    assign o_evt = i_ctl.en ? evt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear)) begin
            r_phase  <= PH_SEEK;
            r_target <= 18'd2;
            r_start  <= '0;
            r_len    <= '0;
        end else if (i_ctl.step && i_ctl.en) begin
            r_phase  <= n_phase;
            r_target <= n_target;
            r_start  <= n_start;
            r_len    <= n_len;
        end
    end

endmodule

>>> rtl/image_header_size_sniffer_unit.sv
`timescale 1ns / 1ps

// Image header size sniffer. Takes a file one byte per transfer, with last_byte on its
// final byte, recognises PNG, GIF, BMP or JPEG from the magic bytes and returns exactly
// one result per file: found with format, width and height as soon as the header bytes
// holding them have arrived, or a not-found result with all fields zero at the last byte.
// The block sustains one byte per clock. A byte is held in an input register, then its
// header decode and capture are combinational into the result register, which holds the
// result until it is taken. Input keeps flowing while a result waits to be taken; only a
// second result due before the first is taken stalls the input.
// Bytes beyond the first 64 KiB of a file are ignored apart from their last-byte mark.

module image_header_size_sniffer_unit
    import isn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    isn_in_if.sink    i_in,
    isn_out_if.source o_out
);

    logic             r_in_vld;
    logic [7:0]       r_byte;
    logic             r_last;

    logic [POS_W-1:0] r_pos;
    t_fmt             r_fmt, n_fmt, magic;
    logic             r_given;
    logic [31:0]      r_w, n_w, r_h, n_h;

    logic             r_o_vld;
    logic             r_o_found;
    t_fmt             r_o_fmt;
    logic [31:0]      r_o_w, r_o_h;

    logic             live, active, done, hit, produce, adv, in_rdy;
    t_jpeg_ctl        jctl;
    t_jpeg_evt        jevt;

    assign in_rdy      = !r_in_vld || adv;
    assign i_in.ready  = in_rdy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_rdy) begin
            r_in_vld <= i_in.valid;
        end
        if (in_rdy && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    assign live   = (r_pos != SCAN_LIMIT);
    assign active = live && !r_given;

    // magic byte check
    always_comb begin
        magic = r_fmt;
        case (r_pos)
            17'd0: begin
                if (r_byte == MAGIC_PNG0) magic = FMT_PNG;
                else if (r_byte == "G") magic = FMT_GIF;
                else if (r_byte == "B") magic = FMT_BMP;
                else if (r_byte == MAGIC_JPG0) magic = FMT_JPEG;
                else magic = FMT_NONE;
            end
            17'd1: begin
                if ((r_fmt == FMT_PNG && r_byte != "P")
                    || (r_fmt == FMT_GIF && r_byte != "I")
                    || (r_fmt == FMT_BMP && r_byte != "M")
                    || (r_fmt == FMT_JPEG && r_byte != MAGIC_JPG1)) magic = FMT_NONE;
            end
            17'd2: begin
                if ((r_fmt == FMT_PNG && r_byte != "N")
                    || (r_fmt == FMT_GIF && r_byte != "F")) magic = FMT_NONE;
            end
            17'd3: begin
                if (r_fmt == FMT_PNG && r_byte != "G") magic = FMT_NONE;
            end
            default: magic = r_fmt;
        endcase
    end

    assign n_fmt = (active && r_pos < 17'd4) ? magic : r_fmt;

    assign jctl.en    = active && (n_fmt == FMT_JPEG) && (r_pos >= 17'd2);
    assign jctl.step  = adv;
    assign jctl.clear = r_last;
    assign jctl.pos   = r_pos;
    assign jctl.data  = r_byte;

    isn_jpeg u_jpeg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (jctl),
        .o_evt   (jevt)
    );

    // dimension capture
    always_comb begin
        n_w  = r_w;
        n_h  = r_h;
        done = 1'b0;
        case (n_fmt)
            FMT_PNG: begin
                if (r_pos >= 17'd16 && r_pos <= 17'd19) n_w = {r_w[23:0], r_byte};
                if (r_pos >= 17'd20 && r_pos <= 17'd23) n_h = {r_h[23:0], r_byte};
                done = (r_pos == 17'd23);
            end
            FMT_GIF: begin
                if (r_pos == 17'd6) n_w = {24'd0, r_byte};
                if (r_pos == 17'd7) n_w = {r_w[31:16], r_byte, r_w[7:0]};
                if (r_pos == 17'd8) n_h = {24'd0, r_byte};
                if (r_pos == 17'd9) n_h = {r_h[31:16], r_byte, r_h[7:0]};
                done = (r_pos == 17'd9);
            end
            FMT_BMP: begin
                for (int k = 0; k < 4; k++) begin
                    if (r_pos == 17'(18 + k)) n_w[8*k +: 8] = r_w[8*k +: 8] | r_byte;
                    if (r_pos == 17'(22 + k)) n_h[8*k +: 8] = r_h[8*k +: 8] | r_byte;
                end
                if (r_pos == 17'd25 && n_h[31]) n_h = ~n_h + 32'd1;
                done = (r_pos == 17'd25);
            end
            FMT_JPEG: begin
                if (jevt.cap_h_hi) n_h = {24'd0, r_byte};
                if (jevt.cap_h_lo) n_h = {r_h[23:0], r_byte};
                if (jevt.cap_w_hi) n_w = {24'd0, r_byte};
                if (jevt.cap_w_lo) n_w = {r_w[23:0], r_byte};
                done = jevt.done;
            end
            default: done = 1'b0;
        endcase
    end

    assign hit     = active && done;
    assign produce = hit || (r_last && !r_given);
    assign adv     = r_in_vld && (!produce || !r_o_vld || o_out.ready);

    // per-file state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_last)) begin
            r_pos   <= '0;
            r_fmt   <= FMT_NONE;
            r_given <= 1'b0;
            r_w     <= '0;
            r_h     <= '0;
        end else if (adv && active) begin
            r_pos   <= r_pos + 17'd1;
            r_fmt   <= n_fmt;
            r_given <= hit;
            r_w     <= n_w;
            r_h     <= n_h;
        end else if (adv && live) begin
            r_pos   <= r_pos + 17'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv && produce) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
        if (adv && produce) begin
            r_o_found <= hit;
            r_o_fmt   <= hit ? n_fmt : FMT_NONE;
            r_o_w     <= hit ? n_w : 32'd0;
            r_o_h     <= hit ? n_h : 32'd0;
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.found        = r_o_found;
    assign o_out.image_format = r_o_fmt;
    assign o_out.pixel_width  = r_o_w;
    assign o_out.pixel_height = r_o_h;

endmodule

>>> rtl/isn_chk.sv
`timescale 1ns / 1ps

module isn_chk
    import isn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [2:0]  i_image_format,
    input logic [31:0] i_pixel_width,
    input logic [31:0] i_pixel_height
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found)
            && $stable(i_image_format) && $stable(i_pixel_width)
            && $stable(i_pixel_height))
        else $error("stalled result changed");

    // not-found result carries zeros
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_image_format == FMT_NONE
            && i_pixel_width == 32'd0 && i_pixel_height == 32'd0)
        else $error("not-found result with non-zero fields");

    // 16-bit header fields for gif and jpeg
    a_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found && (i_image_format == FMT_GIF || i_image_format == FMT_JPEG)
            |-> i_pixel_width[31:16] == 16'd0 && i_pixel_height[31:16] == 16'd0)
        else $error("gif or jpeg dimension wider than 16 bits");

endmodule

bind image_header_size_sniffer_unit isn_chk u_isn_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_found        (o_out.found),
    .i_image_format (o_out.image_format),
    .i_pixel_width  (o_out.pixel_width),
    .i_pixel_height (o_out.pixel_height)
);

>>> bench/image_header_size_sniffer_unit_tb.sv
`timescale 1ns / 1ps

module image_header_size_sniffer_unit_tb;
    import isn_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 700;

    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] APP0_CODE = 8'hE0;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
        bit          drain;
    } t_feed;

    typedef struct {
        logic               found;
        t_fmt               fmt;
        logic signed [31:0] w;
        logic signed [31:0] h;
    } t_dims;

    logic i_clk;
    logic i_rst_n;

    isn_in_if  in_if ();
    isn_out_if out_if ();

    image_header_size_sniffer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_feed      feed_q[$];
    t_dims      dims_due[$];
    logic [7:0] fb[$];

    // predictor state for the file in flight
    logic [16:0] hdr_pos;
    t_fmt        hdr_fmt;
    bit          hdr_done;
    logic [31:0] acc_w;
    logic [31:0] acc_h;
    logic [17:0] scan_tgt;
    t_jphase     jp_phase;
    logic [16:0] jp_mark;
    logic [15:0] seg_len;

    int          faults;
    int          results_seen;
    int          quiet_cycles;
    bit          byte_taken;
    bit          dims_taken;
    bit          feeding;
    bit          byte_shown;
    int unsigned gap_left;
    int unsigned stall_left;
    t_feed       next_byte;

    function automatic bit frame_marker(input logic [7:0] m);
        return (m[7:4] == SOF_FIRST[7:4]) && (m[1:0] != 2'b00 || m[3:0] == 4'h0);
    endfunction

    task automatic clear_sniffer();
        hdr_pos  = '0;
        hdr_fmt  = FMT_NONE;
        hdr_done = 1'b0;
        acc_w    = '0;
        acc_h    = '0;
        scan_tgt = 18'd2;
        jp_phase = PH_SEEK;
        jp_mark  = '0;
        seg_len  = '0;
    endtask

    task automatic sniff_byte(input logic [7:0] b, input logic last);
        logic [16:0] rel;
        int          k;
        bit          hit;
        t_dims       res;
        hit = 1'b0;
        if (hdr_pos < SCAN_LIMIT) begin
            if (!hdr_done) begin
                k   = int'(hdr_pos);
                rel = hdr_pos - jp_mark;
                case (k)
                    0: begin
                        if (b == MAGIC_PNG0) hdr_fmt = FMT_PNG;
                        else if (b == CH_G) hdr_fmt = FMT_GIF;
                        else if (b == CH_B) hdr_fmt = FMT_BMP;
                        else if (b == MAGIC_JPG0) hdr_fmt = FMT_JPEG;
                        else hdr_fmt = FMT_NONE;
                    end
                    1: begin
                        if ((hdr_fmt == FMT_PNG && b != CH_P) || (hdr_fmt == FMT_GIF && b != CH_I)
                            || (hdr_fmt == FMT_BMP && b != CH_M)
                            || (hdr_fmt == FMT_JPEG && b != MAGIC_JPG1))
                            hdr_fmt = FMT_NONE;
                    end
                    2: begin
                        if ((hdr_fmt == FMT_PNG && b != CH_N) || (hdr_fmt == FMT_GIF && b != CH_F))
                            hdr_fmt = FMT_NONE;
                    end
                    3: begin
                        if (hdr_fmt == FMT_PNG && b != CH_G) hdr_fmt = FMT_NONE;
                    end
                    default: ;
                endcase
                case (hdr_fmt)
                    FMT_PNG: begin
                        if (k >= 16 && k <= 19) acc_w = {acc_w[23:0], b};
                        if (k >= 20 && k <= 23) acc_h = {acc_h[23:0], b};
                        hit = (k == 23);
                    end
                    FMT_GIF: begin
                        case (k)
                            6: acc_w[7:0] = b;
                            7: acc_w[15:8] = b;
                            8: acc_h[7:0] = b;
                            9: acc_h[15:8] = b;
                            default: ;
                        endcase
                        hit = (k == 9);
                    end
                    FMT_BMP: begin
                        if (k >= 18 && k <= 21) acc_w[8*(k-18) +: 8] = b;
                        if (k >= 22 && k <= 25) acc_h[8*(k-22) +: 8] = b;
                        if (k == 25) begin
                            if (acc_h[31]) acc_h = -acc_h;
                            hit = 1'b1;
                        end
                    end
                    FMT_JPEG: begin
                        if (k >= 2) begin
                            case (jp_phase)
                                PH_SEEK: begin
                                    if ({1'b0, hdr_pos} == scan_tgt) begin
                                        if (b != JPG_MARK) begin
                                            scan_tgt = scan_tgt + 18'd1;
                                        end else begin
                                            jp_mark  = hdr_pos;
                                            jp_phase = PH_CODE;
                                        end
                                    end
                                end
                                PH_CODE: jp_phase = frame_marker(b) ? PH_FRAME : PH_LENHI;
                                PH_FRAME: begin
                                    case (rel)
                                        5: acc_h = {24'd0, b};
                                        6: acc_h = {acc_h[23:0], b};
                                        7: acc_w = {24'd0, b};
                                        8: acc_w = {acc_w[23:0], b};
                                        9: hit = 1'b1;
                                        default: ;
                                    endcase
                                end
                                PH_LENHI: begin
                                    seg_len  = {8'd0, b};
                                    jp_phase = PH_LENLO;
                                end
                                PH_LENLO: begin
                                    seg_len = {seg_len[7:0], b};
                                    // short lengths resume right after the length bytes
                                    if (seg_len < 16'd2)
                                        scan_tgt = {1'b0, jp_mark} + 18'd4;
                                    else
                                        scan_tgt = {1'b0, jp_mark} + 18'd2 + {2'b00, seg_len};
                                    jp_phase = PH_SEEK;
                                end
                                default: jp_phase = PH_SEEK;
                            endcase
                        end
                    end
                    default: ;
                endcase
                if (hit) begin
                    res.found = 1'b1;
                    res.fmt   = hdr_fmt;
                    res.w     = acc_w;
                    res.h     = acc_h;
                    dims_due.push_back(res);
                    hdr_done = 1'b1;
                end
            end
            hdr_pos = hdr_pos + 17'd1;
        end
        if (last) begin
            if (!hdr_done) begin
                res.found = 1'b0;
                res.fmt   = FMT_NONE;
                res.w     = '0;
                res.h     = '0;
                dims_due.push_back(res);
            end
            clear_sniffer();
        end
    endtask

    // file builders
    task automatic put_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) fb.push_back(v[8*i +: 8]);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) fb.push_back(v[8*i +: 8]);
    endtask

    task automatic put_rand(input int n);
        repeat (n) fb.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_pad();
        repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom_range(0, 254)));
    endtask

    task automatic put_seg(input logic [7:0] code, input int len);
        fb.push_back(JPG_MARK);
        fb.push_back(code);
        put_be(len, 2);
        if (len >= 2) put_rand(len - 2);
    endtask

    task automatic put_sof(input logic [7:0] code, input logic [15:0] h, input logic [15:0] w);
        fb.push_back(JPG_MARK);
        fb.push_back(code);
        put_be(32'h11, 2);
        fb.push_back(8'h08);
        put_be(h, 2);
        put_be(w, 2);
        fb.push_back(8'h03);
    endtask

    task automatic build_png(input logic [31:0] w, input logic [31:0] h);
        fb.push_back(MAGIC_PNG0);
        fb.push_back(CH_P);
        fb.push_back(CH_N);
        fb.push_back(CH_G);
        put_rand(12);
        put_be(w, 4);
        put_be(h, 4);
    endtask

    task automatic build_gif(input logic [15:0] w, input logic [15:0] h);
        fb.push_back(CH_G);
        fb.push_back(CH_I);
        fb.push_back(CH_F);
        put_rand(3);
        put_le(w, 2);
        put_le(h, 2);
    endtask

    task automatic build_bmp(input logic [31:0] w, input logic [31:0] h);
        fb.push_back(CH_B);
        fb.push_back(CH_M);
        put_rand(16);
        put_le(w, 4);
        put_le(h, 4);
    endtask

    task automatic build_jpeg(input int nseg, input logic [7:0] sof,
                              input logic [15:0] h, input logic [15:0] w);
        logic [7:0] code;
        int         len;
        int         r;
        fb.push_back(MAGIC_JPG0);
        fb.push_back(MAGIC_JPG1);
        repeat (nseg) begin
            put_pad();
            do code = 8'($urandom_range(0, 255)); while (frame_marker(code));
            r = $urandom_range(0, 7);
            if (r == 0) len = $urandom_range(0, 1);
            else if (r == 7) len = $urandom_range(2, 300);
            else len = $urandom_range(2, 20);
            put_seg(code, len);
        end
        put_pad();
        put_sof(sof, h, w);
    endtask

    task automatic trim_file(input int n);
        while (fb.size() > n) void'(fb.pop_back());
    endtask

    task automatic queue_file(input bit calm, input bit drain);
        t_feed f;
        for (int i = 0; i < fb.size(); i++) begin
            f.data  = fb[i];
            f.last  = (i == fb.size() - 1);
            f.gap   = calm ? 0 : $urandom_range(0, 9);
            f.drain = drain && (i == 0);
            feed_q.push_back(f);
        end
        fb.delete();
    endtask

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = 8'h00;
        in_if.last_byte   = 1'b0;
        out_if.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // transfer monitor and predictor
    always @(posedge i_clk) begin
        t_dims want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sniff_byte(in_if.data_byte, in_if.last_byte);
                byte_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                dims_taken = 1'b1;
                results_seen++;
                if (dims_due.size() == 0) begin
                    $error("unexpected result: found %0b format %0d width %0d height %0d",
                           out_if.found, out_if.image_format, out_if.pixel_width,
                           out_if.pixel_height);
                    faults++;
                end else begin
                    want = dims_due.pop_front();
                    if (out_if.found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, out_if.found);
                        faults++;
                    end
                    if (out_if.image_format !== want.fmt) begin
                        $error("image_format: expected %0d, actual %0d", want.fmt,
                               out_if.image_format);
                        faults++;
                    end
                    if (out_if.pixel_width !== want.w) begin
                        $error("pixel_width: expected %0d, actual %0d", want.w,
                               out_if.pixel_width);
                        faults++;
                    end
                    if (out_if.pixel_height !== want.h) begin
                        $error("pixel_height: expected %0d, actual %0d", want.h,
                               out_if.pixel_height);
                        faults++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (byte_taken) begin
                byte_taken = 1'b0;
                feeding    = 1'b0;
                byte_shown = 1'b0;
            end
            if (!feeding && feed_q.size() != 0) begin
                next_byte = feed_q.pop_front();
                gap_left  = next_byte.gap;
                feeding   = 1'b1;
            end
            if (!feeding) begin
                in_if.valid <= 1'b0;
            end else if (!byte_shown) begin
                if (gap_left != 0) begin
                    in_if.valid <= 1'b0;
                    gap_left--;
                end else if (next_byte.drain && dims_due.size() != 0) begin
                    in_if.valid <= 1'b0;
                end else begin
                    in_if.valid     <= 1'b1;
                    in_if.data_byte <= next_byte.data;
                    in_if.last_byte <= next_byte.last;
                    byte_shown = 1'b1;
                end
            end
        end
    end

    // result sink with random stalls, none for a stretch every 32 results
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (dims_taken) begin
                dims_taken = 1'b0;
                stall_left = (results_seen % 32 < 8) ? 0 : $urandom_range(0, 9);
            end
            if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int base;
        int r;
        int k;
        clear_sniffer();

        build_png(32'hFFFF_FFFF, 32'h0000_0000);
        put_rand(3);
        queue_file(1'b0, 1'b0);
        build_png(32'h8000_0000, 32'h7FFF_FFFF);
        queue_file(1'b1, 1'b0);
        build_gif(16'hFFFF, 16'h0000);
        put_rand(2);
        queue_file(1'b0, 1'b0);
        build_gif(16'h0000, 16'hFFFF);
        queue_file(1'b0, 1'b0);
        build_bmp(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_file(1'b0, 1'b0);
        build_bmp(32'h0000_0000, 32'h8000_0000);
        queue_file(1'b1, 1'b0);
        build_bmp(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        put_rand(1);
        queue_file(1'b0, 1'b0);

        // non-frame codes in the frame range and short lengths before the frame
        fb.push_back(MAGIC_JPG0);
        fb.push_back(MAGIC_JPG1);
        put_seg(DHT_CODE, 4);
        put_seg(JPG_CODE, 2);
        put_seg(DAC_CODE, 0);
        put_seg(APP0_CODE, 1);
        fb.push_back(8'h00);
        put_sof(SOF_FIRST | 8'h02, 16'hFFFF, 16'h0000);
        put_rand(2);
        queue_file(1'b0, 1'b1);
        build_jpeg(1, SOF_FIRST, 16'h0000, 16'hFFFF);
        queue_file(1'b0, 1'b0);
        build_jpeg(2, SOF_LAST, 16'h1234, 16'h5678);
        put_rand(4);
        queue_file(1'b0, 1'b0);

        // unknown, single byte and broken headers
        fb.push_back(8'h00);
        put_rand(4);
        queue_file(1'b0, 1'b0);
        fb.push_back(MAGIC_PNG0);
        queue_file(1'b0, 1'b0);
        fb.push_back(CH_G);
        queue_file(1'b1, 1'b0);
        build_png(32'h1, 32'h2);
        trim_file(20);
        queue_file(1'b0, 1'b0);
        build_gif(16'h10, 16'h20);
        fb[1] = CH_M;
        queue_file(1'b0, 1'b0);
        fb.push_back(MAGIC_JPG0);
        fb.push_back(8'h00);
        put_rand(12);
        queue_file(1'b0, 1'b0);
        build_png(32'h3, 32'h4);
        fb[3] = 8'h00;
        queue_file(1'b0, 1'b0);
        build_bmp(32'h5, 32'h6);
        trim_file(25);
        queue_file(1'b0, 1'b0);
        build_jpeg(0, SOF_FIRST, 16'h1, 16'h1);
        trim_file(fb.size() - 1);
        queue_file(1'b0, 1'b0);

        base = feed_q.size();
        while (feed_q.size() - base < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1: build_png(pick_dim(), pick_dim());
                2, 3: build_gif(16'(pick_dim()), 16'(pick_dim()));
                4: build_bmp(pick_dim(), pick_dim());
                5, 6, 7: begin
                    do r = SOF_FIRST | $urandom_range(0, 15); while (!frame_marker(8'(r)));
                    build_jpeg($urandom_range(0, 3), 8'(r), 16'(pick_dim()),
                               16'(pick_dim()));
                end
                default: put_rand($urandom_range(1, 40));
            endcase
            put_rand($urandom_range(0, 5));
            r = $urandom_range(0, 9);
            if (r == 0) begin
                trim_file($urandom_range(1, fb.size()));
            end else if (r == 1) begin
                k = $urandom_range(0, (fb.size() < 4) ? fb.size() - 1 : 3);
                fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            queue_file($urandom_range(0, 4) == 0, $urandom_range(0, 19) == 0);
        end

        do @(negedge i_clk);
        while (!i_rst_n || feed_q.size() != 0 || feeding || dims_due.size() != 0);
        repeat (20) @(posedge i_clk);
        if (dims_due.size() != 0) begin
            $error("%0d results never arrived", dims_due.size());
            faults++;
        end
        if (faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> image_header_size_sniffer_unit.f
rtl/isn_pkg.sv
rtl/isn_if.sv
rtl/isn_jpeg.sv
rtl/image_header_size_sniffer_unit.sv
rtl/isn_chk.sv
bench/image_header_size_sniffer_unit_tb.sv
